[design/key_debounce_short_long_press_top_defines.svh]
// ---------------------------------------------------------------------------
// Key debounce assertion macros
// Shared concurrent assertion helpers; the using module provides clk and
// rst_n.
// ---------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_TOP_DEFINES_SVH

// Same-cycle implication
`define KDSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KDSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/kdsl_pkg.sv]
// ---------------------------------------------------------------------------
// kdsl_pkg
// Types and constants shared by the key debounce block.
// ---------------------------------------------------------------------------
package kdsl_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W      = 8;
  localparam int HELD_W     = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

  localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd3;
  localparam logic [HELD_W-1:0] LONG_RESET = 16'd100;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HELD_W-1:0] long_press_ticks;
  } kdsl_cfg_t;

endpackage

[design/kdsl_cfg_regs.sv]
// ---------------------------------------------------------------------------
// kdsl_cfg_regs
// Configuration register file: decodes the write port into the debounce
// and long-press thresholds.
// ---------------------------------------------------------------------------
module kdsl_cfg_regs import kdsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output kdsl_cfg_t             cfg
);

  logic [DEB_W-1:0]  debounce_r;
  logic [HELD_W-1:0] long_press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEB_RESET;
      long_press_r <= LONG_RESET;
    end else if (cfg_we) begin
      // drop writes to unknown indexes
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[DEB_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[HELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.debounce_ticks   = debounce_r;
  assign cfg.long_press_ticks = long_press_r;

endmodule

[design/kdsl_fsm.sv]
// ---------------------------------------------------------------------------
// kdsl_fsm
// Debounce state machine with confirm and held-duration counters; computes
// the event for one key sample and updates state when stepped.
// ---------------------------------------------------------------------------
`include "key_debounce_short_long_press_top_defines.svh"

module kdsl_fsm import kdsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  kdsl_cfg_t cfg,
  input  logic      step_en,
  input  logic      key_level,
  output evt_t      evt
);

  typedef enum logic [1:0] {
    MODE_RELEASED    = 2'd0,
    MODE_PRESS_CONF  = 2'd1,
    MODE_PRESSED     = 2'd2,
    MODE_RELEASE_CONF = 2'd3
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic [DEB_W-1:0]  confirm_r, confirm_nxt, confirm_inc;
  logic [HELD_W-1:0] held_r, held_nxt, held_inc;
  logic              low;

  assign low         = ~key_level;
  assign confirm_inc = (confirm_r == {DEB_W{1'b1}}) ? confirm_r : confirm_r + 1'b1;
  assign held_inc    = (held_r == {HELD_W{1'b1}}) ? held_r : held_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    confirm_nxt = confirm_r;
    held_nxt    = held_r;
    evt         = EVT_NONE;
    unique case (mode_r)
      MODE_RELEASED: begin
        if (low) begin
          held_nxt = '0;
          mode_nxt = MODE_PRESS_CONF;
        end
      end
      MODE_PRESS_CONF: begin
        if (low) begin
          if (confirm_inc >= cfg.debounce_ticks) begin
            mode_nxt    = MODE_PRESSED;
            confirm_nxt = '0;
          end else begin
            confirm_nxt = confirm_inc;
          end
        end else begin
          mode_nxt    = MODE_RELEASED;
          confirm_nxt = '0;
        end
      end
      MODE_PRESSED: begin
        if (low) begin
          held_nxt = held_inc;
        end else begin
          // this tick does not count toward the release
          mode_nxt    = MODE_RELEASE_CONF;
          confirm_nxt = '0;
        end
      end
      MODE_RELEASE_CONF: begin
        if (!low) begin
          if (confirm_inc >= cfg.debounce_ticks) begin
            evt         = (held_r >= cfg.long_press_ticks) ? EVT_LONG : EVT_SHORT;
            mode_nxt    = MODE_RELEASED;
            confirm_nxt = '0;
          end else begin
            confirm_nxt = confirm_inc;
          end
        end else begin
          mode_nxt    = MODE_PRESSED;
          confirm_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RELEASED;
      confirm_r <= '0;
      held_r    <= '0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      confirm_r <= confirm_nxt;
      held_r    <= held_nxt;
    end
  end

  `KDSL_ASSERT_NOW(a_evt_src, step_en && evt != EVT_NONE, mode_r == MODE_RELEASE_CONF && key_level, "event outside release confirm")
  `KDSL_ASSERT_NEXT(a_evt_rel, step_en && evt != EVT_NONE, mode_r == MODE_RELEASED && confirm_r == '0, "event did not return to released")
  `KDSL_ASSERT_NOW(a_conf_idle, mode_r == MODE_RELEASED || mode_r == MODE_PRESSED, confirm_r == '0, "confirm count live outside confirm states")

endmodule

[design/key_debounce_short_long_press_top.sv]
// ---------------------------------------------------------------------------
// key_debounce_short_long_press_top
// Debounces a scanned key level and reports a short or long press on each
// confirmed release. One sample word enters per cycle unless in_stall is high:
// an input register feeds the state machine, whose update writes the result
// register, so one event word leaves per sample. in_stall rises only while
// both registers hold words and out_stall is high. The user must write the
// thresholds through the cfg port only while no word is in flight (unchecked).
// ---------------------------------------------------------------------------
`include "key_debounce_short_long_press_top_defines.svh"

module key_debounce_short_long_press_top import kdsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_key_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_code
);

  kdsl_cfg_t cfg;
  evt_t      evt;
  evt_t      out_evt_r;
  logic      s1_valid_r, s1_key_r;
  logic      out_valid_r;
  logic      out_free, step_en;

  kdsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kdsl_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (step_en),
    .key_level (s1_key_r),
    .evt       (evt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_key_r <= in_key_level;
    end
    if (step_en) begin
      out_evt_r <= evt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_evt_r;

  `KDSL_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r && out_valid_r, "input stalled with a free slot")

endmodule

[bench/key_debounce_short_long_press_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// key_debounce_short_long_press_top_tb
// Drives sampled key levels through the debouncer under random source gaps
// and sink stalls, tracks the press state machine alongside the block and
// compares every event word with the tracked value.
// ---------------------------------------------------------------------------
module key_debounce_short_long_press_top_tb;
  import kdsl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic LEVEL_DOWN = 1'b0;
  localparam logic LEVEL_UP   = 1'b1;

  typedef enum logic [1:0] {
    KEY_UP           = 2'd0,
    KEY_PRESS_CONF   = 2'd1,
    KEY_DOWN         = 2'd2,
    KEY_RELEASE_CONF = 2'd3
  } key_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_key_level = LEVEL_UP;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_event_code;

  // Tracked block state and registers
  key_mode_t         key_mode_q = KEY_UP;
  logic [DEB_W-1:0]  confirm_q = '0;
  logic [HELD_W-1:0] held_q = '0;
  logic [DEB_W-1:0]  debounce_q = DEB_RESET;
  logic [HELD_W-1:0] long_press_q = LONG_RESET;

  evt_t pending_events[$];
  int   levels_sent = 0;
  int   err_count = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   idle_en = 1'b0;

  key_debounce_short_long_press_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_level   (in_key_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_debounce_short_long_press_top regression: fail");
      $finish;
    end
  end

  // Sink side: random stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13);
    end
    out_stall = (stall_left != 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("event_code: expected nothing, actual %0d", out_event_code);
        err_count++;
      end else begin
        if (out_event_code !== pending_events[0]) begin
          $error("event_code: expected %0d, actual %0d", pending_events[0], out_event_code);
          err_count++;
        end
        void'(pending_events.pop_front());
      end
    end
  end

  // Advance the tracked state machine by one sampled level
  task automatic step_key(input logic level, output evt_t evt);
    evt = EVT_NONE;
    case (key_mode_q)
      KEY_UP: begin
        if (level == LEVEL_DOWN) begin
          held_q = '0;
          key_mode_q = KEY_PRESS_CONF;
        end
      end
      KEY_PRESS_CONF: begin
        if (level == LEVEL_DOWN) begin
          if (confirm_q != '1) confirm_q++;
          if (confirm_q >= debounce_q) begin
            key_mode_q = KEY_DOWN;
            confirm_q = '0;
          end
        end else begin
          key_mode_q = KEY_UP;
          confirm_q = '0;
        end
      end
      KEY_DOWN: begin
        if (level == LEVEL_DOWN) begin
          if (held_q != '1) held_q++;
        end else begin
          key_mode_q = KEY_RELEASE_CONF;
          confirm_q = '0;
        end
      end
      default: begin
        if (level == LEVEL_UP) begin
          if (confirm_q != '1) confirm_q++;
          if (confirm_q >= debounce_q) begin
            evt = (held_q >= long_press_q) ? EVT_LONG : EVT_SHORT;
            key_mode_q = KEY_UP;
            confirm_q = '0;
          end
        end else begin
          key_mode_q = KEY_DOWN;
          confirm_q = '0;
        end
      end
    endcase
  endtask

  task automatic send_level(input logic level);
    evt_t evt;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_key_level = level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_key(level, evt);
    pending_events.push_back(evt);
    levels_sent++;
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_level(level);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DEBOUNCE:   debounce_q = data[DEB_W-1:0];
      CFG_LONG_PRESS: long_press_q = data;
      default: ;
    endcase
  endtask

  // Reset values: a short press with the power-on thresholds
  task automatic test_reset_thresholds();
    send_run(LEVEL_DOWN, 6);
    send_run(LEVEL_UP, 4);
  endtask

  // Upper data bits dropped, spare indexes ignored, zero debounce and zero threshold
  task automatic test_register_masking();
    write_reg(CFG_DEBOUNCE, 16'hFF00);
    write_reg(CFG_LONG_PRESS, 16'h0000);
    write_reg(CFG_SPARE_2, 16'h00FF);
    write_reg(CFG_SPARE_3, 16'hFFFF);
    send_run(LEVEL_DOWN, 2);
    send_run(LEVEL_UP, 2);
    write_reg(CFG_DEBOUNCE, 16'hAB01);
    send_run(LEVEL_DOWN, 2);
    send_run(LEVEL_UP, 2);
  endtask

  // Bounce in both confirm states
  task automatic test_bounce();
    write_reg(CFG_DEBOUNCE, 16'd2);
    write_reg(CFG_LONG_PRESS, 16'd3);
    send_level(LEVEL_DOWN);
    send_level(LEVEL_UP);
    send_run(LEVEL_DOWN, 6);
    send_level(LEVEL_UP);
    send_level(LEVEL_DOWN);
    send_run(LEVEL_UP, 3);
  endtask

  // Hold one tick short of the threshold, exactly at it, and against the largest threshold
  task automatic test_long_threshold();
    write_reg(CFG_DEBOUNCE, 16'd1);
    write_reg(CFG_LONG_PRESS, 16'd40);
    send_run(LEVEL_DOWN, 41);
    send_run(LEVEL_UP, 2);
    send_run(LEVEL_DOWN, 42);
    send_run(LEVEL_UP, 2);
    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    send_run(LEVEL_DOWN, 60);
    send_run(LEVEL_UP, 2);
  endtask

  task automatic random_press(input int deb);
    int hold;
    if (long_press_q <= 200 && $urandom_range(0, 1) == 1) begin
      hold = int'(long_press_q) - 2 + $urandom_range(0, 4);
      if (hold < 0) hold = 0;
    end else begin
      hold = $urandom_range(0, 60);
    end
    repeat ($urandom_range(0, 2)) begin
      send_run(LEVEL_DOWN, $urandom_range(1, deb));
      send_run(LEVEL_UP, $urandom_range(1, 3));
    end
    send_run(LEVEL_DOWN, 1 + deb + hold);
    repeat ($urandom_range(0, 2)) begin
      send_run(LEVEL_UP, $urandom_range(1, deb));
      send_run(LEVEL_DOWN, $urandom_range(1, 3));
    end
    send_run(LEVEL_UP, 1 + deb + $urandom_range(0, 3));
  endtask

  task automatic random_phase(input logic [DEB_W-1:0] deb, input logic [HELD_W-1:0] lp,
                              input int count);
    logic [DEB_W-1:0] junk;
    int stop_at;
    int deb_eff;
    int pick;
    junk = DEB_W'($urandom);
    write_reg(CFG_DEBOUNCE, {junk, deb});
    write_reg(CFG_LONG_PRESS, lp);
    deb_eff = (deb == 0) ? 1 : int'(deb);
    stop_at = levels_sent + count;
    while (levels_sent < stop_at) begin
      pick = $urandom_range(0, 49);
      if (pick == 0) begin
        wait_drained();
      end else if (pick < 36) begin
        random_press(deb_eff);
      end else if (pick < 44) begin
        // aborted press: up before the debounce completes
        send_run(LEVEL_DOWN, $urandom_range(1, deb_eff));
        send_run(LEVEL_UP, $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 10)) send_level(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random();
    idle_en = 1'b1;
    random_phase(8'd1, 16'd1, 100);
    random_phase(8'd0, 16'd0, 80);
    // one random sequence at the longest debounce
    random_phase(8'd255, 16'd300, 1);
    repeat (4) random_phase(DEB_W'($urandom_range(1, 8)), HELD_W'($urandom_range(1, 40)), 110);
    random_phase(8'd2, 16'hFFFF, 60);
    // quiet tail
    idle_en = 1'b0;
    random_phase(8'd2, 16'd20, 150);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_thresholds();
    test_register_masking();
    test_bounce();
    test_long_threshold();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("key_debounce_short_long_press_top regression: pass");
    end else begin
      $display("key_debounce_short_long_press_top regression: fail");
    end
    $finish;
  end

endmodule
